FILE: rtl/csbp_pkg.sv
// Package for the clock-sweep buffer pool frame table.
// Holds request and status codes and the frame descriptor type; no dependencies.
package csbp_pkg;
	localparam int PAGE_W = 31;
	localparam int PIN_W = 8;
	localparam logic [PIN_W-1:0] PIN_MAX = '1;

	typedef enum logic [1:0] {
		OP_FETCH = 2'd0,
		OP_UNPIN = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_LOADED     = 3'd1,
		ST_ALL_PINNED = 3'd2,
		ST_NOT_RES    = 3'd3,
		ST_NOT_PINNED = 3'd4
	} status_t;

	typedef struct packed {
		logic              valid;
		logic              referenced;
		logic              dirty;
		logic [PIN_W-1:0]  pins;
		logic [PAGE_W-1:0] page;
	} frame_t;
endpackage

FILE: rtl/clock_sweep_buffer_pool_unit.sv
// Top level of the clock-sweep buffer pool frame table.
// Uses csbp_pkg and a ring of csbp_frame_cell instances.
//
// The frames live in a ring of cells that rotates one place per cycle while
// the hand sweeps or steps on after an eviction; cell 0 always sits under the
// clock hand, and a rotation counter tracks which physical frame number that
// is. A hit, unpin, flush or a miss with a free frame is accepted, then
// executed; a miss that sweeps then visits frames under the hand until it
// evicts one and steps the hand, or reports that all frames are pinned. One
// request is processed at a time; the result register lets a new request be
// taken while the previous result waits, and execution holds until it drains.
module clock_sweep_buffer_pool_unit #(
	parameter int FRAMES = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                opcode,
	input  logic [csbp_pkg::PAGE_W-1:0] page_number,
	input  logic                      mark_dirty,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                status,
	output logic [2:0]                frame_index,
	output logic                      read_needed,
	output logic                      evict_valid,
	output logic [csbp_pkg::PAGE_W-1:0] evicted_page,
	output logic                      writeback_needed
);
	import csbp_pkg::*;

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int SW = $clog2(2 * FRAMES + 1);
	localparam logic [FW-1:0] LAST = FW'(FRAMES - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic [PAGE_W-1:0] page_q;
	logic dirty_q;
	logic [FW-1:0] rot_q;
	logic [SW-1:0] scan_q;

	frame_t cur [FRAMES];
	frame_t wr_data [FRAMES];
	logic wr_en [FRAMES];
	logic rotate;
	frame_t last_in;

	logic res_full_q;
	logic [2:0] r_status_q, r_fidx_q;
	logic r_rd_q, r_ev_q, r_wb_q;
	logic [PAGE_W-1:0] r_evp_q;

	genvar g;
	generate
		for (g = 0; g < FRAMES; g++) begin : g_cell
			csbp_frame_cell u_cell (
				.clk(clk), .arst_n(arst_n), .rotate(rotate),
				.wr_en(wr_en[g]), .wr_data(wr_data[g]),
				.prev((g == FRAMES - 1) ? last_in : cur[(g + 1) % FRAMES]),
				.cur(cur[g])
			);
		end
	endgenerate

	// lookup over cells; cell c holds physical frame (rot_q + c) mod FRAMES
	logic hit;
	logic [FW-1:0] hit_cell, hit_phys, free_cell, free_phys;
	logic free_any;
	logic [FW-1:0] phys [FRAMES];

	always_comb begin
		for (int c = 0; c < FRAMES; c++) begin
			logic [FW:0] s;
			s = {1'b0, rot_q} + (FW+1)'(c);
			phys[c] = (s >= (FW+1)'(FRAMES)) ? FW'(s - (FW+1)'(FRAMES)) : s[FW-1:0];
		end
	end

	always_comb begin
		hit = 1'b0;
		hit_cell = '0;
		hit_phys = '0;
		free_any = 1'b0;
		free_cell = '0;
		free_phys = '0;
		for (int c = 0; c < FRAMES; c++) begin
			if (cur[c].valid && cur[c].page == page_q &&
			    (!hit || phys[c] < hit_phys)) begin
				hit = 1'b1;
				hit_cell = FW'(c);
				hit_phys = phys[c];
			end
			if (!cur[c].valid && (!free_any || phys[c] < free_phys)) begin
				free_any = 1'b1;
				free_cell = FW'(c);
				free_phys = phys[c];
			end
		end
	end

	frame_t hf, ff, h0;
	assign hf = cur[hit_cell];
	assign h0 = cur[0];

	always_comb begin
		ff.valid = 1'b1;
		ff.referenced = 1'b1;
		ff.dirty = 1'b0;
		ff.pins = PIN_W'(1);
		ff.page = page_q;
	end

	logic res_load;
	logic [2:0] n_status, n_fidx;
	logic n_rd, n_ev, n_wb;
	logic [PAGE_W-1:0] n_evp;
	state_t state_d;
	logic clr_ref0;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		rotate = 1'b0;
		res_load = 1'b0;
		clr_ref0 = 1'b0;
		n_status = ST_OK;
		n_fidx = '0;
		n_rd = 1'b0;
		n_ev = 1'b0;
		n_evp = '0;
		n_wb = 1'b0;
		for (int c = 0; c < FRAMES; c++) begin
			wr_en[c] = 1'b0;
			wr_data[c] = cur[c];
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (!res_full_q || !out_stall) begin
					case (op_q)
						OP_FETCH: begin
							if (hit) begin
								wr_en[hit_cell] = 1'b1;
								wr_data[hit_cell].referenced = 1'b1;
								if (hf.pins != PIN_MAX)
									wr_data[hit_cell].pins = hf.pins + PIN_W'(1);
								n_fidx = 3'(hit_phys);
								res_load = 1'b1;
								state_d = S_IDLE;
							end else if (free_any) begin
								wr_en[free_cell] = 1'b1;
								wr_data[free_cell] = ff;
								n_status = ST_LOADED;
								n_rd = 1'b1;
								n_fidx = 3'(free_phys);
								res_load = 1'b1;
								state_d = S_IDLE;
							end else begin
								state_d = S_SWEEP;
							end
						end
						OP_UNPIN: begin
							res_load = 1'b1;
							state_d = S_IDLE;
							if (!hit) begin
								n_status = ST_NOT_RES;
							end else if (hf.pins == '0) begin
								n_status = ST_NOT_PINNED;
								n_fidx = 3'(hit_phys);
							end else begin
								wr_en[hit_cell] = 1'b1;
								wr_data[hit_cell].pins = hf.pins - PIN_W'(1);
								if (dirty_q)
									wr_data[hit_cell].dirty = 1'b1;
								n_fidx = 3'(hit_phys);
							end
						end
						OP_FLUSH: begin
							res_load = 1'b1;
							state_d = S_IDLE;
							if (!hit) begin
								n_status = ST_NOT_RES;
							end else begin
								wr_en[hit_cell] = 1'b1;
								wr_data[hit_cell].dirty = 1'b0;
								n_wb = hf.dirty;
								n_fidx = 3'(hit_phys);
							end
						end
						default: begin
							res_load = 1'b1;
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SWEEP: begin
				if (scan_q == SW'(2 * FRAMES)) begin
					n_status = ST_ALL_PINNED;
					res_load = 1'b1;
					state_d = S_IDLE;
				end else if (h0.pins == '0 && !h0.referenced) begin
					wr_en[0] = 1'b1;
					wr_data[0] = ff;
					n_status = ST_LOADED;
					n_rd = 1'b1;
					n_ev = 1'b1;
					n_evp = h0.page;
					n_wb = h0.dirty;
					n_fidx = 3'(rot_q);
					res_load = 1'b1;
					state_d = S_DONE;
				end else begin
					rotate = 1'b1;
					clr_ref0 = (h0.pins == '0);
				end
			end
			S_DONE: begin
				rotate = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// cleared reference bit travels with the rotating descriptor
	always_comb begin
		last_in = h0;
		if (clr_ref0)
			last_in.referenced = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rot_q <= '0;
			scan_q <= '0;
			res_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rotate)
				rot_q <= (rot_q == LAST) ? '0 : rot_q + FW'(1);
			if (state_q == S_EXEC)
				scan_q <= '0;
			else if (rotate)
				scan_q <= scan_q + SW'(1);
			if (res_load)
				res_full_q <= 1'b1;
			else if (!out_stall)
				res_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= opcode;
			page_q <= page_number;
			dirty_q <= mark_dirty;
		end
		if (res_load) begin
			r_status_q <= n_status;
			r_fidx_q <= n_fidx;
			r_rd_q <= n_rd;
			r_ev_q <= n_ev;
			r_evp_q <= n_evp;
			r_wb_q <= n_wb;
		end
	end

	assign out_valid = res_full_q;
	assign status = r_status_q;
	assign frame_index = r_fidx_q;
	assign read_needed = r_rd_q;
	assign evict_valid = r_ev_q;
	assign evicted_page = r_evp_q;
	assign writeback_needed = r_wb_q;

	a_one_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accept while busy");
	a_done_rot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> rot_q != $past(rot_q) || FRAMES == 1)
		else $error("hand did not advance after eviction");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
endmodule

FILE: rtl/csbp_frame_cell.sv
// One frame cell of the rotating frame ring.
// Holds a frame descriptor, passes it to the next cell on rotate, applies updates.
// Depends on csbp_pkg.
module csbp_frame_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rotate,
	input  logic             wr_en,
	input  csbp_pkg::frame_t wr_data,
	input  csbp_pkg::frame_t prev,
	output csbp_pkg::frame_t cur
);
	import csbp_pkg::*;

	frame_t frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (rotate) begin
			frame_q <= prev;
		end else if (wr_en) begin
			frame_q <= wr_data;
		end
	end

	assign cur = frame_q;
endmodule
